@@ hw/rtl/mmfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max feature scaler: shared package
// Job classification codes, status codes, fixed widths and the control record
// that travels with each request from the front end to the back end.
// ----------------------------------------------------------------------------
package mmfs_pkg;

	localparam int IDX_W  = 4;   // feature index width
	localparam int CNT_W  = 5;   // feature count register width
	localparam int OUT_W  = 24;  // Q7.16 result width
	localparam int INT_W  = 8;   // integer quotient bits (the quotient is at most 128)
	localparam int FRAC_W = 17;  // fraction bits, one more than the result for rounding
	localparam int QUO_W  = INT_W + FRAC_W;

	localparam logic [CNT_W-1:0] FEATURE_COUNT_RST = 5'd16;

	// Word index of the feature count register on the configuration port.
	localparam logic REG_FEATURE_COUNT = 1'b0;

	// Rounded magnitude limits for positive and negative results.
	localparam logic [QUO_W-1:0] MAG_LIMIT_POS = 25'd8388607;
	localparam logic [QUO_W-1:0] MAG_LIMIT_NEG = 25'd8388608;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_UNFIT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_FIT = 2'd0,
		K_DIV = 2'd1,
		K_ERR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic             load;
		status_t          status;
		logic [IDX_W-1:0] index;
	} job_ctrl_t;

	localparam int CTRL_W = $bits(job_ctrl_t);

endpackage

@@ hw/rtl/mmfs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max feature scaler: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmfs_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/mmfs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max feature scaler: front end
// Accepts a request, reads the feature's bounds once no fit is outstanding,
// classifies the request and hands it to the job queue.
// ----------------------------------------------------------------------------
module mmfs_front #(
	parameter int MAX_FEATURES = 16,
	parameter int VALUE_WIDTH  = 32,
	parameter int ADDR_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            op,
	input  logic [mmfs_pkg::IDX_W-1:0]      feature_index,
	input  logic                            first_sample,
	input  logic signed [VALUE_WIDTH-1:0]   sample_value,
	input  logic [mmfs_pkg::CNT_W-1:0]      feature_count,
	input  logic [MAX_FEATURES-1:0]         fitted,
	input  logic                            fit_done,
	output logic                            rd_en,
	output logic [ADDR_W-1:0]               rd_addr,
	input  logic signed [VALUE_WIDTH-1:0]   rd_min,
	input  logic signed [VALUE_WIDTH-1:0]   rd_max,
	input  logic                            q_full,
	output logic                            push,
	output mmfs_pkg::job_ctrl_t             push_ctrl,
	output logic signed [VALUE_WIDTH-1:0]   push_value,
	output logic signed [VALUE_WIDTH-1:0]   push_min,
	output logic signed [VALUE_WIDTH-1:0]   push_max
);

	import mmfs_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_WAIT,
		F_CLASS
	} fstate_t;

	fstate_t                 state_q;
	logic [1:0]              pend_q;
	logic                    op_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    first_q;
	logic signed [VALUE_WIDTH-1:0] value_q;

	logic accept;
	logic in_range;
	logic fit_bit;
	logic push_fit;

	assign accept  = (state_q == F_IDLE) && start;
	assign busy    = (state_q != F_IDLE);
	assign rd_addr = ADDR_W'(idx_q);
	// Bounds may only be read once every earlier fit has been written back.
	assign rd_en   = (state_q == F_WAIT) && (pend_q == 2'd0);
	assign push    = (state_q == F_CLASS) && !q_full;

	assign in_range = ({1'b0, idx_q} < feature_count) && (32'(idx_q) < MAX_FEATURES);
	assign fit_bit  = fitted[rd_addr];

	always_comb begin
		push_ctrl.index  = idx_q;
		push_ctrl.load   = first_q || !fit_bit;
		push_ctrl.status = ST_OK;
		push_ctrl.kind   = K_DIV;
		if (!in_range) begin
			push_ctrl.kind   = K_ERR;
			push_ctrl.status = ST_RANGE;
		end else if (!op_q) begin
			push_ctrl.kind   = K_FIT;
		end else if (!fit_bit) begin
			push_ctrl.kind   = K_ERR;
			push_ctrl.status = ST_UNFIT;
		end
	end

	assign push_value = value_q;
	assign push_min   = rd_min;
	assign push_max   = rd_max;
	assign push_fit   = push && (push_ctrl.kind == K_FIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pend_q  <= 2'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_WAIT;
					end
				end
				F_WAIT: begin
					if (rd_en) begin
						state_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
			case ({push_fit, fit_done})
				2'b10:   pend_q <= pend_q + 2'd1;
				2'b01:   pend_q <= pend_q - 2'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			idx_q   <= feature_index;
			first_q <= first_sample;
			value_q <= sample_value;
		end
	end

endmodule

@@ hw/rtl/mmfs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max feature scaler: job queue
// Two-entry first-in first-out buffer between the front end and back end.
// ----------------------------------------------------------------------------
module mmfs_queue #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full    = (cnt_q == (PTR_W + 1)'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ hw/rtl/mmfs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max feature scaler: back end
// Carries out queued jobs: bound updates for fits, and a radix-2 restoring
// division with rounding and clamping for transforms. Drives the result.
// ----------------------------------------------------------------------------
module mmfs_back #(
	parameter int MAX_FEATURES = 16,
	parameter int VALUE_WIDTH  = 32,
	parameter int ADDR_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              pop,
	input  mmfs_pkg::job_ctrl_t               head_ctrl,
	input  logic signed [VALUE_WIDTH-1:0]     head_value,
	input  logic signed [VALUE_WIDTH-1:0]     head_min,
	input  logic signed [VALUE_WIDTH-1:0]     head_max,
	output logic                              wr_en,
	output logic [ADDR_W-1:0]                 wr_addr,
	output logic signed [VALUE_WIDTH-1:0]     wr_min,
	output logic signed [VALUE_WIDTH-1:0]     wr_max,
	output logic [MAX_FEATURES-1:0]           fitted,
	output logic                              fit_done,
	output logic                              done,
	output logic [1:0]                        status,
	output logic signed [mmfs_pkg::OUT_W-1:0] scaled_value,
	output logic                              saturated,
	output logic [mmfs_pkg::IDX_W-1:0]        echo_index
);

	import mmfs_pkg::*;

	localparam int VW     = VALUE_WIDTH;
	localparam int STEP_W = $clog2(QUO_W);

	typedef enum logic [2:0] {
		B_IDLE,
		B_SETUP,
		B_CHECK,
		B_DIV,
		B_ROUND
	} bstate_t;

	bstate_t                 state_q;
	logic                    done_q;
	status_t                 status_q;
	logic signed [OUT_W-1:0] scaled_q;
	logic                    sat_q;
	logic [IDX_W-1:0]        echo_q;
	logic [MAX_FEATURES-1:0] fitted_q;
	logic [STEP_W-1:0]       step_q;

	logic [IDX_W-1:0]        idx_q;
	logic signed [VW-1:0]    value_q;
	logic signed [VW-1:0]    min_q;
	logic signed [VW-1:0]    max_q;
	logic                    neg_q;
	logic [VW-1:0]           mag_q;
	logic [VW-1:0]           den_q;
	logic [VW-1:0]           rem_q;
	logic [QUO_W-1:0]        sh_q;
	logic [QUO_W-1:0]        quo_q;

	logic signed [VW:0]      num;
	logic signed [VW:0]      rng;
	logic [VW:0]             num_mag;
	logic [VW+7:0]           sat_bound;
	logic                    too_big;
	logic [VW:0]             trial;
	logic [VW:0]             trial_sub;
	logic                    trial_ge;
	logic [QUO_W-1:0]        rounded;
	logic [QUO_W-1:0]        limit;
	logic                    clamp;
	logic [QUO_W-1:0]        res_mag;
	logic [QUO_W-1:0]        res_neg;
	logic signed [OUT_W-1:0] res_final;

	// Fit update straight from the head of the queue.
	assign pop      = (state_q == B_IDLE) && q_valid;
	assign wr_en    = pop && (head_ctrl.kind == K_FIT);
	assign fit_done = wr_en;
	assign wr_addr  = ADDR_W'(head_ctrl.index);
	assign wr_min   = (head_ctrl.load || (head_value < head_min)) ? head_value : head_min;
	assign wr_max   = (head_ctrl.load || (head_value > head_max)) ? head_value : head_max;

	// Operand set-up: magnitude of the offset from the minimum, and the range.
	assign num     = (VW + 1)'(value_q) - (VW + 1)'(min_q);
	assign rng     = (VW + 1)'(max_q) - (VW + 1)'(min_q);
	assign num_mag = num[VW] ? ((VW + 1)'(0) - num) : num;

	// An integer part above 128 is the same as the offset reaching 129 ranges.
	assign sat_bound = {1'b0, den_q, 7'b0} + (VW + 8)'(den_q);
	assign too_big   = ((VW + 8)'(mag_q) >= sat_bound);

	// One quotient bit per cycle.
	assign trial     = {rem_q, sh_q[QUO_W-1]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	// Round to nearest with ties away from zero, then clamp and apply the sign.
	assign rounded   = (quo_q >> 1) + QUO_W'(quo_q[0]);
	assign limit     = neg_q ? MAG_LIMIT_NEG : MAG_LIMIT_POS;
	assign clamp     = (rounded > limit);
	assign res_mag   = clamp ? limit : rounded;
	assign res_neg   = QUO_W'(0) - res_mag;
	assign res_final = neg_q ? res_neg[OUT_W-1:0] : res_mag[OUT_W-1:0];

	assign fitted       = fitted_q;
	assign done         = done_q;
	assign status       = status_q;
	assign scaled_value = scaled_q;
	assign saturated    = sat_q;
	assign echo_index   = echo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			scaled_q <= '0;
			sat_q    <= 1'b0;
			echo_q   <= '0;
			fitted_q <= '0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						case (head_ctrl.kind)
							K_FIT: begin
								fitted_q[wr_addr] <= 1'b1;
								done_q   <= 1'b1;
								status_q <= ST_OK;
								scaled_q <= '0;
								sat_q    <= 1'b0;
								echo_q   <= head_ctrl.index;
							end
							K_DIV: begin
								state_q <= B_SETUP;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= head_ctrl.status;
								scaled_q <= '0;
								sat_q    <= 1'b0;
								echo_q   <= head_ctrl.index;
							end
						endcase
					end
				end
				B_SETUP: begin
					state_q <= B_CHECK;
				end
				B_CHECK: begin
					step_q <= '0;
					if (den_q == '0) begin
						state_q  <= B_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						scaled_q <= '0;
						sat_q    <= 1'b0;
						echo_q   <= idx_q;
					end else if (too_big) begin
						state_q  <= B_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						scaled_q <= neg_q ? OUT_MIN : OUT_MAX;
						sat_q    <= 1'b1;
						echo_q   <= idx_q;
					end else begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(QUO_W - 1)) begin
						state_q <= B_ROUND;
					end
				end
				B_ROUND: begin
					state_q  <= B_IDLE;
					done_q   <= 1'b1;
					status_q <= ST_OK;
					scaled_q <= res_final;
					sat_q    <= clamp;
					echo_q   <= idx_q;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					idx_q   <= head_ctrl.index;
					value_q <= head_value;
					min_q   <= head_min;
					max_q   <= head_max;
				end
			end
			B_SETUP: begin
				neg_q <= num[VW];
				mag_q <= num_mag[VW-1:0];
				den_q <= rng[VW-1:0];
			end
			B_CHECK: begin
				// The top of the dividend is already below the divisor here.
				rem_q <= mag_q >> INT_W;
				sh_q  <= {mag_q[INT_W-1:0], {FRAC_W{1'b0}}};
				quo_q <= '0;
			end
			B_DIV: begin
				rem_q <= trial_ge ? trial_sub[VW-1:0] : trial[VW-1:0];
				sh_q  <= sh_q << 1;
				quo_q <= {quo_q[QUO_W-2:0], trial_ge};
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/min_max_feature_scaler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max feature scaler: top level
// Per-feature minimum and maximum tracking with a fixed-point scaling
// transform, behind a command interface and a register port.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low.
// op selects fit (0), which loads or widens the bounds of feature
// feature_index, or transform (1), which returns (value - min) / (max - min)
// as signed Q7.16, rounded to nearest with ties away from zero and clamped
// with saturated set. Every request yields exactly one result, shown for a
// single cycle with done high; the receiver must take it then, as there is
// no way to hold results back. A transform occupies the back end from the
// cycle that takes it from the queue through operand set-up, a range check
// that ends the job early for a zero range or a saturated result, the
// one-bit-per-cycle divider and a rounding step, and the back end takes no
// further job until its result is out. Fits and error answers are finished
// in the cycle that takes them from the queue. The front end takes no new
// request until the current one has been pushed into the two-entry job
// queue, and waits while that queue is full; a request that follows a fit also
// waits in the front end until that fit has been written to the bound
// memories. feature_count is written through the register port at byte
// address 0 and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module min_max_feature_scaler_top #(
	parameter int MAX_FEATURES = 16,
	parameter int VALUE_WIDTH  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// Request
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [mmfs_pkg::IDX_W-1:0]        feature_index,
	input  logic                              first_sample,
	input  logic signed [VALUE_WIDTH-1:0]     sample_value,
	// Result
	output logic                              done,
	output logic [1:0]                        status,
	output logic signed [mmfs_pkg::OUT_W-1:0] scaled_value,
	output logic                              saturated,
	output logic [mmfs_pkg::IDX_W-1:0]        echo_index
);

	import mmfs_pkg::*;

	localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int QW     = CTRL_W + 3 * VALUE_WIDTH;

	logic [CNT_W-1:0] feature_count_q;

	// Front end to memories and queue
	logic                          rd_en;
	logic [ADDR_W-1:0]             rd_addr;
	logic signed [VALUE_WIDTH-1:0] rd_min;
	logic signed [VALUE_WIDTH-1:0] rd_max;
	logic                          push;
	job_ctrl_t                     push_ctrl;
	logic signed [VALUE_WIDTH-1:0] push_value;
	logic signed [VALUE_WIDTH-1:0] push_min;
	logic signed [VALUE_WIDTH-1:0] push_max;
	logic                          q_full;

	// Queue to back end
	logic                          q_valid;
	logic                          pop;
	logic [QW-1:0]                 q_rd;
	job_ctrl_t                     head_ctrl;
	logic signed [VALUE_WIDTH-1:0] head_value;
	logic signed [VALUE_WIDTH-1:0] head_min;
	logic signed [VALUE_WIDTH-1:0] head_max;

	// Back end write-back
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	logic signed [VALUE_WIDTH-1:0] wr_min;
	logic signed [VALUE_WIDTH-1:0] wr_max;
	logic [MAX_FEATURES-1:0]       fitted;
	logic                          fit_done;

	// Register port: a single register, written on the access phase.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FEATURE_COUNT) ? 32'(feature_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_count_q <= FEATURE_COUNT_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FEATURE_COUNT)) begin
			feature_count_q <= pwdata[CNT_W-1:0];
		end
	end

	mmfs_front #(
		.MAX_FEATURES (MAX_FEATURES),
		.VALUE_WIDTH  (VALUE_WIDTH),
		.ADDR_W       (ADDR_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.feature_index (feature_index),
		.first_sample  (first_sample),
		.sample_value  (sample_value),
		.feature_count (feature_count_q),
		.fitted        (fitted),
		.fit_done      (fit_done),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_min        (rd_min),
		.rd_max        (rd_max),
		.q_full        (q_full),
		.push          (push),
		.push_ctrl     (push_ctrl),
		.push_value    (push_value),
		.push_min      (push_min),
		.push_max      (push_max)
	);

	// The minimum and maximum of each feature live in two identical memories.
	mmfs_ram #(
		.WIDTH  (VALUE_WIDTH),
		.DEPTH  (MAX_FEATURES),
		.ADDR_W (ADDR_W)
	) u_min_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_min),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_min)
	);

	mmfs_ram #(
		.WIDTH  (VALUE_WIDTH),
		.DEPTH  (MAX_FEATURES),
		.ADDR_W (ADDR_W)
	) u_max_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_max),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_max)
	);

	mmfs_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({push_ctrl, push_value, push_min, push_max}),
		.full    (q_full),
		.pop     (pop),
		.valid   (q_valid),
		.rd_data (q_rd)
	);

	assign head_ctrl  = q_rd[QW-1 -: CTRL_W];
	assign head_value = q_rd[3*VALUE_WIDTH-1 -: VALUE_WIDTH];
	assign head_min   = q_rd[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
	assign head_max   = q_rd[VALUE_WIDTH-1:0];

	mmfs_back #(
		.MAX_FEATURES (MAX_FEATURES),
		.VALUE_WIDTH  (VALUE_WIDTH),
		.ADDR_W       (ADDR_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.pop          (pop),
		.head_ctrl    (head_ctrl),
		.head_value   (head_value),
		.head_min     (head_min),
		.head_max     (head_max),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_min       (wr_min),
		.wr_max       (wr_max),
		.fitted       (fitted),
		.fit_done     (fit_done),
		.done         (done),
		.status       (status),
		.scaled_value (scaled_value),
		.saturated    (saturated),
		.echo_index   (echo_index)
	);

endmodule
